// ===== rtl/tcf_pkg.sv =====
// tcf_pkg: shared types, constants and helper functions for the tilt
// complementary filter. No dependencies; every rtl file imports it.

package tcf_pkg;

   // sample and arithmetic widths
   localparam int SAMPLE_W      = 32;
   localparam int COEF_FRAC     = 30;
   localparam int ANGLE_FRAC    = 28;
   localparam int COEF_W        = 34;
   localparam int DIFF_W        = SAMPLE_W + 2;
   localparam int OPA_W         = (COEF_W > DIFF_W) ? COEF_W : DIFF_W;
   localparam int PROD_W        = OPA_W + SAMPLE_W;
   localparam int ACC_W         = PROD_W + 4;
   localparam int PERIOD_HALF_W = 16;
   localparam int TRAP_SHIFT    = ANGLE_FRAC + 1 - PERIOD_HALF_W;
   localparam int TRAP_W        = DIFF_W + PERIOD_HALF_W + 1;

   // filter sequencing
   localparam int TAPS       = 4;
   localparam int TAP_W      = $clog2(TAPS);
   localparam int MAC_TERMS  = 2 * TAPS + 1;
   localparam int K_W        = $clog2(MAC_TERMS);
   localparam int HIST_IDX_W = TAP_W + 3;
   localparam int HIST_DEPTH = 1 << HIST_IDX_W;

   localparam int CSR_IDX_W  = 3;
   localparam logic [SAMPLE_W-1:0] SAMPLE_PERIOD_RESET = 32'd21474836;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
   localparam logic signed [ACC_W-1:0]  ROUND_HALF = ACC_W'(1) << (COEF_FRAC - 1);
   localparam logic signed [PROD_W-1:0] TRAP_HALF  = PROD_W'(1) << ANGLE_FRAC;

   // coefficients, Q4.30; feedback terms are stored negated
   localparam logic signed [COEF_W-1:0] HP_B0 =  34'sd874294280;
   localparam logic signed [COEF_W-1:0] HP_B1 = -34'sd3497177121;
   localparam logic signed [COEF_W-1:0] HP_B2 =  34'sd5245765681;
   localparam logic signed [COEF_W-1:0] LP_B0 =  34'sd33543;
   localparam logic signed [COEF_W-1:0] LP_B1 =  34'sd134175;
   localparam logic signed [COEF_W-1:0] LP_B2 =  34'sd201251;
   localparam logic signed [COEF_W-1:0] NEG_A1 =  34'sd3854411026;
   localparam logic signed [COEF_W-1:0] NEG_A2 = -34'sd5209043711;
   localparam logic signed [COEF_W-1:0] NEG_A3 =  34'sd3139728470;
   localparam logic signed [COEF_W-1:0] NEG_A4 = -34'sd711900590;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SAMPLE_PERIOD    = 3'd0,
      CSR_RATE_BIAS_X      = 3'd1,
      CSR_RATE_BIAS_Y      = 3'd2,
      CSR_DRIFT_X          = 3'd3,
      CSR_DRIFT_Y          = 3'd4,
      CSR_INTEGRATE_ENABLE = 3'd5
   } tcf_csr_idx_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SUM,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_TRAP,
      ST_ANG,
      ST_DRIFT,
      ST_MAC,
      ST_MAC_LAST,
      ST_ROUND,
      ST_FUSE,
      ST_EMIT
   } tcf_state_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] rate_x;
      logic signed [SAMPLE_W-1:0] rate_y;
      logic signed [SAMPLE_W-1:0] tilt_x;
      logic signed [SAMPLE_W-1:0] tilt_y;
   } tcf_req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] fused_x;
      logic signed [SAMPLE_W-1:0] fused_y;
   } tcf_rsp_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0]        sample_period;
      logic signed [SAMPLE_W-1:0] rate_bias_x;
      logic signed [SAMPLE_W-1:0] rate_bias_y;
      logic signed [SAMPLE_W-1:0] drift_x;
      logic signed [SAMPLE_W-1:0] drift_y;
      logic                       integrate_enable;
   } tcf_csr_type;

   // sequencer step as seen by the datapath
   typedef struct packed {
      tcf_state_type  state;
      logic           axis;
      logic           pair;
      logic [K_W-1:0] k;
   } tcf_ctrl_type;

   // history shift request: pair 0 is the high-pass, pair 1 the low-pass
   typedef struct packed {
      logic                       en;
      logic                       axis;
      logic                       pair;
      logic signed [SAMPLE_W-1:0] x_data;
      logic signed [SAMPLE_W-1:0] y_data;
   } tcf_hist_wr_type;

   function automatic logic signed [SAMPLE_W-1:0] sat_sample(
      input logic signed [ACC_W-1:0] v
   );
      logic signed [SAMPLE_W-1:0] res;
      if (v > ACC_W'(SAMPLE_MAX)) begin
         res = SAMPLE_MAX;
      end else if (v < ACC_W'(SAMPLE_MIN)) begin
         res = SAMPLE_MIN;
      end else begin
         res = v[SAMPLE_W-1:0];
      end
      return res;
   endfunction

   // term order: feed-forward taps 0..4, then feedback taps 1..4
   function automatic logic signed [COEF_W-1:0] coef_lookup(
      input logic           pair,
      input logic [K_W-1:0] k
   );
      logic signed [COEF_W-1:0] c;
      case ({pair, k})
         {1'b0, 4'd0}: c = HP_B0;
         {1'b0, 4'd1}: c = HP_B1;
         {1'b0, 4'd2}: c = HP_B2;
         {1'b0, 4'd3}: c = HP_B1;
         {1'b0, 4'd4}: c = HP_B0;
         {1'b1, 4'd0}: c = LP_B0;
         {1'b1, 4'd1}: c = LP_B1;
         {1'b1, 4'd2}: c = LP_B2;
         {1'b1, 4'd3}: c = LP_B1;
         {1'b1, 4'd4}: c = LP_B0;
         {1'b0, 4'd5}, {1'b1, 4'd5}: c = NEG_A1;
         {1'b0, 4'd6}, {1'b1, 4'd6}: c = NEG_A2;
         {1'b0, 4'd7}, {1'b1, 4'd7}: c = NEG_A3;
         {1'b0, 4'd8}, {1'b1, 4'd8}: c = NEG_A4;
         default: c = '0;
      endcase
      return c;
   endfunction

endpackage

// ===== rtl/tcf_hist_file.sv =====
// tcf_hist_file: sample history of both filters on both axes, four taps each,
// one read port and one shift port that moves a filter's x and y histories at once. Depends on tcf_pkg.

module tcf_hist_file import tcf_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [HIST_IDX_W-1:0]      rd_idx,
   output logic signed [SAMPLE_W-1:0] rd_data,
   input  tcf_hist_wr_type            wr
);

   logic signed [SAMPLE_W-1:0] hist_ff [HIST_DEPTH];
   logic signed [SAMPLE_W-1:0] hist_in [HIST_DEPTH];
   logic [2:0]                 x_base;
   logic [2:0]                 y_base;

   assign rd_data = hist_ff[rd_idx];
   assign x_base  = {wr.axis, wr.pair, 1'b0};
   assign y_base  = {wr.axis, wr.pair, 1'b1};

   always_comb begin
      hist_in = hist_ff;
      if (wr.en) begin
         for (int t = TAPS - 1; t > 0; t--) begin
            hist_in[{x_base, TAP_W'(t)}] = hist_ff[{x_base, TAP_W'(t - 1)}];
            hist_in[{y_base, TAP_W'(t)}] = hist_ff[{y_base, TAP_W'(t - 1)}];
         end
         hist_in[{x_base, TAP_W'(0)}] = wr.x_data;
         hist_in[{y_base, TAP_W'(0)}] = wr.y_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff <= '{default: '0};
      end else begin
         hist_ff <= hist_in;
      end
   end

endmodule

// ===== rtl/tcf_arith.sv =====
// tcf_arith: shared 34x32 multiplier, accumulator and the add/saturate steps
// for integration, drift, both filters and the fusion. Depends on tcf_pkg.

module tcf_arith import tcf_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  tcf_ctrl_type               ctrl,
   input  tcf_req_type                item,
   input  tcf_csr_type                csr,
   input  logic signed [SAMPLE_W-1:0] hist_rd_data,
   output logic [HIST_IDX_W-1:0]      hist_rd_idx,
   output tcf_hist_wr_type            hist_wr,
   output logic signed [SAMPLE_W-1:0] fused_x,
   output logic signed [SAMPLE_W-1:0] fused_y
);

   logic signed [DIFF_W-1:0]   s_ff, s_in;
   logic signed [TRAP_W-1:0]   tmp_ff, tmp_in;
   logic signed [SAMPLE_W-1:0] ang_ff, ang_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [SAMPLE_W-1:0] hp_ff, hp_in;
   logic signed [SAMPLE_W-1:0] lp_ff, lp_in;
   logic signed [SAMPLE_W-1:0] fx_ff, fx_in;
   logic signed [SAMPLE_W-1:0] fy_ff, fy_in;
   logic signed [SAMPLE_W-1:0] prev_ff [2];
   logic signed [SAMPLE_W-1:0] prev_in [2];

   logic signed [SAMPLE_W-1:0] rate_sel, bias_sel, drift_sel, tilt_sel, x0;
   logic signed [OPA_W-1:0]    mult_a;
   logic signed [SAMPLE_W-1:0] mult_b;
   logic signed [ACC_W-1:0]    rnd_sum;
   logic signed [SAMPLE_W-1:0] y_rnd;
   logic [K_W-1:0]             km1;

   assign rate_sel  = ctrl.axis ? item.rate_y : item.rate_x;
   assign tilt_sel  = ctrl.axis ? item.tilt_y : item.tilt_x;
   assign bias_sel  = ctrl.axis ? csr.rate_bias_y : csr.rate_bias_x;
   assign drift_sel = ctrl.axis ? csr.drift_y : csr.drift_x;
   assign x0        = ctrl.pair ? tilt_sel : ang_ff;

   // history tap for term k: feed-forward taps first, then feedback taps
   assign km1 = ctrl.k - K_W'(1);
   always_comb begin
      if (ctrl.state == ST_ANG) begin
         hist_rd_idx = {ctrl.axis, 1'b0, 1'b0, {TAP_W{1'b0}}};
      end else begin
         hist_rd_idx = {ctrl.axis, ctrl.pair, km1[TAP_W], km1[TAP_W-1:0]};
      end
   end

   always_comb begin
      case (ctrl.state)
         ST_MUL_LO: begin
            mult_a = s_ff;
            mult_b = {{(SAMPLE_W-PERIOD_HALF_W){1'b0}},
                      csr.sample_period[PERIOD_HALF_W-1:0]};
         end
         ST_MUL_HI: begin
            mult_a = s_ff;
            mult_b = {{(SAMPLE_W-PERIOD_HALF_W){1'b0}},
                      csr.sample_period[SAMPLE_W-1:PERIOD_HALF_W]};
         end
         default: begin
            mult_a = OPA_W'(coef_lookup(ctrl.pair, ctrl.k));
            mult_b = (ctrl.k == '0) ? x0 : hist_rd_data;
         end
      endcase
   end

   assign prod_in = PROD_W'(mult_a) * PROD_W'(mult_b);
   assign rnd_sum = acc_ff + ROUND_HALF;
   assign y_rnd   = sat_sample(rnd_sum >>> COEF_FRAC);

   always_comb begin
      s_in    = s_ff;
      tmp_in  = tmp_ff;
      ang_in  = ang_ff;
      acc_in  = acc_ff;
      hp_in   = hp_ff;
      lp_in   = lp_ff;
      fx_in   = fx_ff;
      fy_in   = fy_ff;
      prev_in = prev_ff;
      hist_wr = '0;
      case (ctrl.state)
         ST_SUM: begin
            s_in = DIFF_W'(rate_sel) - DIFF_W'(bias_sel)
                 + DIFF_W'(prev_ff[ctrl.axis]) - DIFF_W'(bias_sel);
            prev_in[ctrl.axis] = rate_sel;
            // angle before drift stays zero when integration is off
            ang_in = '0;
         end
         ST_MUL_HI: begin
            tmp_in = TRAP_W'((prod_ff + TRAP_HALF) >>> PERIOD_HALF_W);
         end
         ST_TRAP: begin
            tmp_in = TRAP_W'((PROD_W'(tmp_ff) + prod_ff) >>> TRAP_SHIFT);
         end
         ST_ANG: begin
            ang_in = sat_sample(ACC_W'(hist_rd_data) + ACC_W'(tmp_ff));
         end
         ST_DRIFT: begin
            ang_in = sat_sample(ACC_W'(ang_ff) - ACC_W'(drift_sel));
         end
         ST_MAC: begin
            acc_in = (ctrl.k == '0) ? '0 : acc_ff + ACC_W'(prod_ff);
         end
         ST_MAC_LAST: begin
            acc_in = acc_ff + ACC_W'(prod_ff);
         end
         ST_ROUND: begin
            if (ctrl.pair) begin
               lp_in = y_rnd;
            end else begin
               hp_in = y_rnd;
            end
            hist_wr.en     = 1'b1;
            hist_wr.axis   = ctrl.axis;
            hist_wr.pair   = ctrl.pair;
            hist_wr.x_data = x0;
            hist_wr.y_data = y_rnd;
         end
         ST_FUSE: begin
            if (ctrl.axis) begin
               fy_in = sat_sample(ACC_W'(hp_ff) + ACC_W'(lp_ff));
            end else begin
               fx_in = sat_sample(ACC_W'(hp_ff) + ACC_W'(lp_ff));
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      s_ff    <= s_in;
      tmp_ff  <= tmp_in;
      ang_ff  <= ang_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      hp_ff   <= hp_in;
      lp_ff   <= lp_in;
      fx_ff   <= fx_in;
      fy_ff   <= fy_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '{default: '0};
      end else begin
         prev_ff <= prev_in;
      end
   end

   assign fused_x = fx_ff;
   assign fused_y = fy_ff;

endmodule

// ===== rtl/tcf_seq.sv =====
// tcf_seq: sequencer stepping one item through integration, drift and the
// two filters of each axis. Depends on tcf_pkg.

module tcf_seq import tcf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         integrate_enable,
   input  logic         out_free,
   output logic         req_ready,
   output tcf_ctrl_type ctrl
);

   tcf_state_type  state_ff, state_in;
   logic           axis_ff, axis_in;
   logic           pair_ff, pair_in;
   logic [K_W-1:0] k_ff, k_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         axis_ff  <= 1'b0;
         pair_ff  <= 1'b0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
         pair_ff  <= pair_in;
         k_ff     <= k_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      axis_in   = axis_ff;
      pair_in   = pair_ff;
      k_in      = k_ff;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               axis_in  = 1'b0;
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            state_in = integrate_enable ? ST_MUL_LO : ST_DRIFT;
         end
         ST_MUL_LO: state_in = ST_MUL_HI;
         ST_MUL_HI: state_in = ST_TRAP;
         ST_TRAP:   state_in = ST_ANG;
         ST_ANG:    state_in = ST_DRIFT;
         ST_DRIFT: begin
            pair_in  = 1'b0;
            k_in     = '0;
            state_in = ST_MAC;
         end
         ST_MAC: begin
            if (k_ff == K_W'(MAC_TERMS - 1)) begin
               state_in = ST_MAC_LAST;
            end else begin
               k_in = k_ff + K_W'(1);
            end
         end
         ST_MAC_LAST: state_in = ST_ROUND;
         ST_ROUND: begin
            if (!pair_ff) begin
               pair_in  = 1'b1;
               k_in     = '0;
               state_in = ST_MAC;
            end else begin
               state_in = ST_FUSE;
            end
         end
         ST_FUSE: begin
            if (!axis_ff) begin
               axis_in  = 1'b1;
               state_in = ST_SUM;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign ctrl.state = state_ff;
   assign ctrl.axis  = axis_ff;
   assign ctrl.pair  = pair_ff;
   assign ctrl.k     = k_ff;

endmodule

// ===== rtl/imu_tilt_complementary_filter.sv =====
// Two-axis tilt complementary filter: each item of gyro rates and tilt angles
// gives one item of fused angles. Items are worked on one at a time, paced by the
// one shared 34x32 multiplier: two products for the trapezoid step (none with
// integration off) and nine per fourth-order filter, four filters per item, one
// product a cycle. A finished item waits in the output register while the next
// one is accepted and worked on.
// Depends on tcf_pkg, tcf_seq, tcf_arith and tcf_hist_file.

module imu_tilt_complementary_filter import tcf_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  tcf_req_type          req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output tcf_rsp_type          rsp_data,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SAMPLE_W-1:0]  csr_wdata
);

   tcf_csr_type     csr_ff, csr_in;
   tcf_req_type     item_ff, item_in;
   logic            rsp_valid_ff, rsp_valid_in;
   tcf_rsp_type     rsp_data_ff, rsp_data_in;

   tcf_ctrl_type               ctrl;
   tcf_hist_wr_type            hist_wr;
   logic [HIST_IDX_W-1:0]      hist_rd_idx;
   logic signed [SAMPLE_W-1:0] hist_rd_data;
   logic signed [SAMPLE_W-1:0] fused_x, fused_y;
   logic                       out_free;
   logic                       emit;

   always_comb begin
      csr_in = csr_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_SAMPLE_PERIOD:    csr_in.sample_period    = csr_wdata;
            CSR_RATE_BIAS_X:      csr_in.rate_bias_x      = csr_wdata;
            CSR_RATE_BIAS_Y:      csr_in.rate_bias_y      = csr_wdata;
            CSR_DRIFT_X:          csr_in.drift_x          = csr_wdata;
            CSR_DRIFT_Y:          csr_in.drift_y          = csr_wdata;
            CSR_INTEGRATE_ENABLE: csr_in.integrate_enable = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.sample_period    <= SAMPLE_PERIOD_RESET;
         csr_ff.rate_bias_x      <= '0;
         csr_ff.rate_bias_y      <= '0;
         csr_ff.drift_x          <= '0;
         csr_ff.drift_y          <= '0;
         csr_ff.integrate_enable <= 1'b0;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // input item held for the whole sequence
   assign item_in = (req_valid && req_ready) ? req_data : item_ff;

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign emit     = (ctrl.state == ST_EMIT) && out_free;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (emit) begin
         rsp_valid_in        = 1'b1;
         rsp_data_in.fused_x = fused_x;
         rsp_data_in.fused_y = fused_y;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   tcf_seq u_seq (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .integrate_enable (csr_ff.integrate_enable),
      .out_free         (out_free),
      .req_ready        (req_ready),
      .ctrl             (ctrl)
   );

   tcf_arith u_arith (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (ctrl),
      .item         (item_ff),
      .csr          (csr_ff),
      .hist_rd_data (hist_rd_data),
      .hist_rd_idx  (hist_rd_idx),
      .hist_wr      (hist_wr),
      .fused_x      (fused_x),
      .fused_y      (fused_y)
   );

   tcf_hist_file u_hist (
      .clock   (clock),
      .reset   (reset),
      .rd_idx  (hist_rd_idx),
      .rd_data (hist_rd_data),
      .wr      (hist_wr)
   );

endmodule

// ===== sim/imu_tilt_complementary_filter_tb.sv =====
`timescale 1ns / 100ps
// Testbench for imu_tilt_complementary_filter: sample items with random gaps and
// back-pressure, fused angles predicted by a bit-exact fixed-point model here.
// Depends on tcf_pkg and the filter rtl.

module imu_tilt_complementary_filter_tb;
   import tcf_pkg::*;

   localparam int LIMIT_CYCLES  = 1_000_000;
   localparam int SEGMENT_ITEMS = 275;
   localparam int SEGMENTS      = 6;
   localparam int LONG_HOLD     = 600;
   localparam int SETTLE_CYCLES = 100;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   // predicts fused angles and holds them until the block hands them over
   class fused_angle_board;
      tcf_rsp_type expected_fused[$];
      int mismatch_count;

      logic [31:0]        period;
      logic signed [31:0] bias[2];
      logic signed [31:0] drift[2];
      logic               integrate_on;

      // histories per axis, newest sample in element 0
      logic signed [31:0] last_rate[2];
      logic [3:0][31:0]   angle_hist[2];
      logic [3:0][31:0]   tilt_hist[2];
      logic [3:0][31:0]   hp_hist[2];
      logic [3:0][31:0]   lp_hist[2];

      longint hp_num[5];
      longint lp_num[5];
      longint den_neg[4];

      function new();
         // coefficients held with 40 fraction bits, rounded to nearest at 30 here
         longint hp40[5] = '{64'sd895277342917, -64'sd3581109371666, 64'sd5371664057500,
                             -64'sd3581109371666, 64'sd895277342917};
         longint lp40[5] = '{64'sd34347644, 64'sd137394973, 64'sd206081464,
                             64'sd137394973, 64'sd34347644};
         longint den40[4] = '{-64'sd3946916890228, 64'sd5334060759830,
                              -64'sd3215081953780, 64'sd728986204332};
         int k;
         for (k = 0; k < 5; k++) begin
            hp_num[k] = (hp40[k] + 64'sd512) >>> 10;
            lp_num[k] = (lp40[k] + 64'sd512) >>> 10;
         end
         for (k = 0; k < 4; k++) begin
            den_neg[k] = -((den40[k] + 64'sd512) >>> 10);
         end
         mismatch_count = 0;
         period = SAMPLE_PERIOD_RESET;
         integrate_on = 1'b0;
         for (k = 0; k < 2; k++) begin
            bias[k] = '0;
            drift[k] = '0;
            last_rate[k] = '0;
            angle_hist[k] = '0;
            tilt_hist[k] = '0;
            hp_hist[k] = '0;
            lp_hist[k] = '0;
         end
      endfunction

      task report_mismatch(string what);
         $display("mismatch at %0t: %s", $time, what);
         mismatch_count++;
      endtask

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] value);
         case (idx)
            CSR_SAMPLE_PERIOD:    period = value;
            CSR_RATE_BIAS_X:      bias[0] = value;
            CSR_RATE_BIAS_Y:      bias[1] = value;
            CSR_DRIFT_X:          drift[0] = value;
            CSR_DRIFT_Y:          drift[1] = value;
            CSR_INTEGRATE_ENABLE: integrate_on = value[0];
            default: ;
         endcase
      endfunction

      function logic signed [31:0] clamp32(logic signed [127:0] v);
         if (v > 128'sd2147483647) return 32'sh7fff_ffff;
         if (v < -128'sd2147483648) return 32'sh8000_0000;
         return v[31:0];
      endfunction

      function logic signed [127:0] product(logic signed [127:0] a, logic signed [127:0] b);
         return a * b;
      endfunction

      // angle step of the trapezoid rule, period split in halves to keep 64 bits
      function longint trapezoid_step(longint s);
         longint a, b, t;
         a = s * longint'(period[31:16]);
         b = s * longint'(period[15:0]);
         t = a + ((b + (64'sd1 <<< 28)) >>> 16);
         return t >>> 13;
      endfunction

      function logic signed [31:0] filter_step(bit lowpass, int ax, logic signed [31:0] x0);
         logic [3:0][31:0]    xh, yh;
         logic signed [127:0] acc;
         logic signed [31:0]  y;
         longint c;
         int k;
         if (lowpass) begin
            xh = tilt_hist[ax];
            yh = lp_hist[ax];
         end else begin
            xh = angle_hist[ax];
            yh = hp_hist[ax];
         end
         c = lowpass ? lp_num[0] : hp_num[0];
         acc = product(c, x0);
         for (k = 0; k < 4; k++) begin
            c = lowpass ? lp_num[k + 1] : hp_num[k + 1];
            acc = acc + product(c, $signed(xh[k]));
            acc = acc + product(den_neg[k], $signed(yh[k]));
         end
         y = clamp32((acc + (128'sd1 <<< 29)) >>> 30);
         xh = {xh[2:0], x0};
         yh = {yh[2:0], y};
         if (lowpass) begin
            tilt_hist[ax] = xh;
            lp_hist[ax] = yh;
         end else begin
            angle_hist[ax] = xh;
            hp_hist[ax] = yh;
         end
         return y;
      endfunction

      function void note_sample(tcf_req_type item);
         tcf_rsp_type        want;
         logic signed [31:0] r, t, ang, hp, lp, fused;
         longint s, raw;
         int ax;
         for (ax = 0; ax < 2; ax++) begin
            r = ax ? item.rate_y : item.rate_x;
            t = ax ? item.tilt_y : item.tilt_x;
            raw = 0;
            if (integrate_on) begin
               s = (longint'(r) - longint'(bias[ax]))
                   + (longint'(last_rate[ax]) - longint'(bias[ax]));
               raw = longint'(clamp32(longint'($signed(angle_hist[ax][0]))
                                      + trapezoid_step(s)));
            end
            ang = clamp32(raw - longint'(drift[ax]));
            last_rate[ax] = r;
            hp = filter_step(1'b0, ax, ang);
            lp = filter_step(1'b1, ax, t);
            fused = clamp32(longint'(hp) + longint'(lp));
            if (ax == 0) want.fused_x = fused;
            else want.fused_y = fused;
         end
         expected_fused.push_back(want);
      endfunction

      task check_fused(tcf_rsp_type got);
         tcf_rsp_type want;
         if (expected_fused.size() == 0) begin
            report_mismatch($sformatf("fused item with none expected, x %0d y %0d",
                                      got.fused_x, got.fused_y));
         end else begin
            want = expected_fused.pop_front();
            if (got.fused_x !== want.fused_x)
               report_mismatch($sformatf("fused_x got %0d want %0d",
                                         got.fused_x, want.fused_x));
            if (got.fused_y !== want.fused_y)
               report_mismatch($sformatf("fused_y got %0d want %0d",
                                         got.fused_y, want.fused_y));
         end
      endtask
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   tcf_req_type          req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   tcf_rsp_type          rsp_data;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [SAMPLE_W-1:0]  csr_wdata = '0;

   fused_angle_board board = new();
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int hold_left = 0;
   logic hold_go = 1'b0;
   logic hold_taken = 1'b0;
   int cycle_count = 0;

   imu_tilt_complementary_filter uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("status: fail");
         $finish;
      end
   end

   // receiver: checks each accepted item, stalls at random or for a long hold
   always @(posedge clock) begin
      if (rsp_valid && rsp_ready) begin
         board.check_fused(rsp_data);
      end
      if (hold_go && !hold_taken) begin
         rsp_ready  <= 1'b0;
         hold_left  <= LONG_HOLD;
         hold_taken <= 1'b1;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // mostly moderate values, with full-scale words and extremes mixed in
   function automatic logic signed [31:0] random_field();
      int pick;
      logic signed [31:0] v;
      pick = $urandom_range(99);
      if (pick < 8) begin
         case ($urandom_range(4))
            0: v = SAMPLE_MAX;
            1: v = SAMPLE_MIN;
            2: v = '0;
            3: v = -32'sd1;
            default: v = 32'sd1;
         endcase
      end else if (pick < 25) begin
         v = $urandom;
      end else begin
         v = $signed($urandom) >>> $urandom_range(12, 2);
      end
      return v;
   endfunction

   function automatic tcf_req_type random_sample();
      tcf_req_type item;
      item.rate_x = random_field();
      item.rate_y = random_field();
      item.tilt_x = random_field();
      item.tilt_y = random_field();
      return item;
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      board.write_reg(idx, value);
   endtask

   task automatic load_settings(input logic [31:0] period, input logic [31:0] bias_x,
                                input logic [31:0] bias_y, input logic [31:0] drift_x,
                                input logic [31:0] drift_y, input logic [31:0] enable);
      write_reg(CSR_SAMPLE_PERIOD, period);
      write_reg(CSR_RATE_BIAS_X, bias_x);
      write_reg(CSR_RATE_BIAS_Y, bias_y);
      write_reg(CSR_DRIFT_X, drift_x);
      write_reg(CSR_DRIFT_Y, drift_y);
      write_reg(CSR_INTEGRATE_ENABLE, enable);
      csr_wr_en <= 1'b0;
   endtask

   task automatic send_sample(input tcf_req_type item);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      board.note_sample(item);
   endtask

   // settings may only change once every fused item is back
   task automatic drain_block();
      req_valid <= 1'b0;
      while (board.expected_fused.size() != 0) @(posedge clock);
   endtask

   initial begin
      int seg, n;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset settings, integration off
      send_sample(tcf_req_type'{32'sd0, 32'sd0, 32'sd0, 32'sd0});
      send_sample(tcf_req_type'{SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX});
      send_sample(tcf_req_type'{SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN});
      send_sample(tcf_req_type'{SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN});
      send_sample(tcf_req_type'{32'sd1, -32'sd1, -32'sd1, 32'sd1});
      drain_block();

      // writes to unused indexes and upper bits of the enable are ignored
      write_reg(CSR_SPARE_LO, 32'hffff_ffff);
      write_reg(CSR_SPARE_HI, 32'h1234_5678);
      write_reg(CSR_INTEGRATE_ENABLE, 32'hffff_fffe);
      csr_wr_en <= 1'b0;
      send_sample(tcf_req_type'{SAMPLE_MAX, SAMPLE_MIN, 32'sd268435456, -32'sd268435456});
      drain_block();

      // longest period and extreme bias and drift: integrator saturates both ways
      load_settings(32'hffff_ffff, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN,
                    32'habcd_0001);
      send_sample(tcf_req_type'{SAMPLE_MAX, SAMPLE_MAX, 32'sd0, 32'sd0});
      send_sample(tcf_req_type'{SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX});
      send_sample(tcf_req_type'{SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN});
      send_sample(tcf_req_type'{SAMPLE_MIN, SAMPLE_MAX, -32'sd1, 32'sd1});
      drain_block();

      // zero period: only drift moves the angle
      load_settings(32'h0, 32'h0, 32'h0, 32'h0100_0000, 32'hff00_0000, 32'h1);
      send_sample(tcf_req_type'{SAMPLE_MAX, SAMPLE_MIN, 32'sd1000, -32'sd1000});
      send_sample(tcf_req_type'{32'sd16777216, -32'sd16777216, 32'sd0, 32'sd0});
      drain_block();

      // drift at the extremes saturates the angle after subtraction
      load_settings(SAMPLE_PERIOD_RESET, 32'h0, 32'h0, SAMPLE_MIN, SAMPLE_MAX, 32'h1);
      send_sample(tcf_req_type'{32'sd16777216, -32'sd16777216, 32'sd0, 32'sd0});
      send_sample(tcf_req_type'{SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN});
      send_sample(tcf_req_type'{32'sd0, 32'sd0, 32'sd0, 32'sd0});
      drain_block();

      for (seg = 0; seg < SEGMENTS; seg++) begin
         tx_idle_pct = (seg < 2) ? 23 : ((seg < 4) ? 63 : 0);
         rx_idle_pct = (seg < 2) ? 63 : ((seg < 4) ? 23 : 0);
         case (seg)
            0: load_settings(SAMPLE_PERIOD_RESET, 32'h0, 32'h0, 32'h0, 32'h0, 32'h1);
            1: load_settings($urandom, random_field(), random_field(), random_field(),
                             random_field(), $urandom | 32'h1);
            2: load_settings(32'hffff_ffff, random_field() >>> 8, random_field() >>> 8,
                             32'h0, 32'h0, 32'h1);
            3: load_settings(random_field(), random_field(), random_field(),
                             random_field(), random_field(), $urandom & ~32'h1);
            4: load_settings(32'h0, random_field(), random_field(),
                             random_field() >>> 16, random_field() >>> 16, 32'h1);
            default: load_settings($urandom, random_field(), random_field(),
                                   random_field(), random_field(), $urandom);
         endcase
         // receiver stops for a long stretch so the block backs up onto its input
         if (seg == 4) hold_go <= 1'b1;
         for (n = 0; n < SEGMENT_ITEMS; n++) begin
            send_sample(random_sample());
         end
         drain_block();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.mismatch_count == 0 && board.expected_fused.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/tcf_pkg.sv
rtl/tcf_hist_file.sv
rtl/tcf_arith.sv
rtl/tcf_seq.sv
rtl/imu_tilt_complementary_filter.sv
sim/imu_tilt_complementary_filter_tb.sv
